// ===== design/iss_pkg.sv =====
// Shared types, signature tables and helper functions for the injection signature scanner.
`default_nettype none

package iss_pkg;

	// Longest signature in either list, in bytes ("onmouseover=").
	localparam int SIG_SPAN     = 12;
	localparam int SQL_COUNT    = 26;
	localparam int SCRIPT_COUNT = 22;

	typedef logic [7:0] byte_t;

	// Byte 0 is the newest byte; a signature is stored with its final character in byte 0
	// and zero padding above its first character.
	typedef logic [SIG_SPAN-1:0][7:0] sig_text_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       last_char;
	} in_beat_t;

	typedef struct packed {
		logic sql_hit;
		logic script_hit;
	} out_beat_t;

	typedef struct packed {
		logic sql;
		logic script;
	} hits_t;

	localparam sig_text_t SQL_SIGS [SQL_COUNT] = '{
		sig_text_t'("select"),
		sig_text_t'("insert"),
		sig_text_t'("update"),
		sig_text_t'("delete"),
		sig_text_t'("drop"),
		sig_text_t'("create"),
		sig_text_t'("alter"),
		sig_text_t'("union"),
		sig_text_t'("join"),
		sig_text_t'("where"),
		sig_text_t'("order by"),
		sig_text_t'("group by"),
		sig_text_t'("having"),
		sig_text_t'("--"),
		sig_text_t'("/*"),
		sig_text_t'("*/"),
		sig_text_t'("xp_"),
		sig_text_t'("sp_"),
		sig_text_t'("@@"),
		sig_text_t'("@@version"),
		sig_text_t'("1=1"),
		sig_text_t'("1 = 1"),
		sig_text_t'("' or '"),
		sig_text_t'("\" or \""),
		sig_text_t'("'; drop"),
		sig_text_t'("\"; drop")
	};

	localparam sig_text_t SCRIPT_SIGS [SCRIPT_COUNT] = '{
		sig_text_t'("<script"),
		sig_text_t'("</script>"),
		sig_text_t'("javascript:"),
		sig_text_t'("onload="),
		sig_text_t'("onerror="),
		sig_text_t'("onclick="),
		sig_text_t'("onmouseover="),
		sig_text_t'("onfocus="),
		sig_text_t'("onblur="),
		sig_text_t'("onchange="),
		sig_text_t'("onsubmit="),
		sig_text_t'("<iframe"),
		sig_text_t'("<object"),
		sig_text_t'("<embed"),
		sig_text_t'("<link"),
		sig_text_t'("<meta"),
		sig_text_t'("<style"),
		sig_text_t'("vbscript:"),
		sig_text_t'("data:"),
		sig_text_t'("eval("),
		sig_text_t'("expression("),
		sig_text_t'("url(")
	};

	// Fold upper-case ASCII letters to lower case; leave every other byte as it is.
	function automatic byte_t fold_byte(input byte_t b);
		byte_t r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

	// True when the signature ends at the newest byte of the window.
	function automatic logic sig_ends(input sig_text_t win, input sig_text_t sig);
		logic ok;
		ok = 1'b1;
		for (int k = 0; k < SIG_SPAN; k++) begin
			if (sig[k] != 8'h00 && win[k] != sig[k]) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

`default_nettype wire

// ===== design/injection_signature_scanner_top.sv =====
// Top level of the injection signature scanner: input stage, matcher, flags and result register.
`default_nettype none

// Scans a string for SQL and script-injection signatures, one byte per beat.
// Input channel (in_valid/in_ready/in_data): one beat carries one byte and a
// last_char mark on the final byte of the string. Letters are folded to lower
// case, so every signature matches in either case. A zero byte empties the
// window so that no signature spans it; the hit flags are kept.
// Output channel (out_valid/out_ready/out_data): one beat per string, sent for
// the beat marked last_char, carrying sql_hit and script_hit for the whole string.
// The final byte enters the input register, and when it leaves, its verdict
// loads the result register. Throughput: one byte per cycle, except while a
// final byte waits as described under Stall. All signatures are compared in
// parallel and combinationally on the window; the window and flags update as
// each byte leaves the input register.
// Stall: a final byte waits in the input register while a previous result is
// still held; non-final bytes keep flowing, so the block stalls only when two
// results queue up. Reset empties the window, clears both flags and drops any
// byte or result in flight.
module injection_signature_scanner_top #(
	parameter int HISTORY_DEPTH = 11
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire iss_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output iss_pkg::out_beat_t  out_data
);
	import iss_pkg::*;

	logic      valid_s1;
	in_beat_t  beat_s1;
	byte_t     folded;
	logic      is_zero;
	logic      retire;
	sig_text_t win;
	hits_t     raw_hits;
	hits_t     hits;
	logic      sql_seen_q;
	logic      script_seen_q;
	logic      out_valid_q;
	out_beat_t out_q;

	// Input register: take a new beat whenever the held one can leave.
	assign retire   = valid_s1 && (!beat_s1.last_char || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			beat_s1 <= in_data;
		end
	end

	assign folded  = fold_byte(beat_s1.char_in);
	assign is_zero = (folded == 8'h00);

	// Window of recent bytes; empty it on a zero byte and at the end of a string.
	iss_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (retire),
		.clear    (is_zero || beat_s1.last_char),
		.new_byte (folded),
		.win      (win)
	);

	iss_matcher u_matcher (
		.win  (win),
		.hits (raw_hits)
	);

	// A zero byte matches nothing.
	assign hits = is_zero ? '0 : raw_hits;

	// Sticky flags: accumulate over the string, drop after the final byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sql_seen_q    <= 1'b0;
			script_seen_q <= 1'b0;
		end else if (retire) begin
			if (beat_s1.last_char) begin
				sql_seen_q    <= 1'b0;
				script_seen_q <= 1'b0;
			end else begin
				sql_seen_q    <= sql_seen_q    | hits.sql;
				script_seen_q <= script_seen_q | hits.script;
			end
		end
	end

	// Result register: load on a final byte, hold until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire && beat_s1.last_char) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire && beat_s1.last_char) begin
			out_q.sql_hit    <= sql_seen_q    | hits.sql;
			out_q.script_hit <= script_seen_q | hits.script;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// ===== design/iss_matcher.sv =====
// Parallel compare of the byte window against the SQL and script signature lists.
`default_nettype none

module iss_matcher (
	input  wire iss_pkg::sig_text_t win,
	output iss_pkg::hits_t          hits
);
	import iss_pkg::*;

	always_comb begin
		hits = '0;
		for (int i = 0; i < SQL_COUNT; i++) begin
			if (sig_ends(win, SQL_SIGS[i])) begin
				hits.sql = 1'b1;
			end
		end
		for (int i = 0; i < SCRIPT_COUNT; i++) begin
			if (sig_ends(win, SCRIPT_SIGS[i])) begin
				hits.script = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/iss_history.sv =====
// Shift register of recent folded bytes, presenting the compare window.
`default_nettype none

module iss_history #(
	parameter int HISTORY_DEPTH = 11
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     advance,
	input  wire                     clear,
	input  wire  [7:0]              new_byte,
	output iss_pkg::sig_text_t      win
);
	import iss_pkg::*;

	logic [HISTORY_DEPTH-1:0][7:0] hist_q;

	// Clear takes precedence over a shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (advance) begin
			if (clear) begin
				hist_q <= '0;
			end else begin
				for (int k = HISTORY_DEPTH - 1; k > 0; k--) begin
					hist_q[k] <= hist_q[k-1];
				end
				hist_q[0] <= new_byte;
			end
		end
	end

	always_comb begin
		win[0] = new_byte;
		for (int k = 1; k < SIG_SPAN; k++) begin
			win[k] = hist_q[k-1];
		end
	end

endmodule

`default_nettype wire
